### hdl/chtab_pkg.sv
// ----------------------------------------------------------------------------
// chtab_pkg
// Shared types and defaults for the chained hash table: request and status
// codes, free list control groups and default table sizes.
// ----------------------------------------------------------------------------
package chtab_pkg;

  // default table geometry
  localparam int unsigned BucketsDef = 16;
  localparam int unsigned NodesDef   = 64;

  // payload widths fixed by the request and result format
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;

  // bits of key consumed per step of the bucket reduction
  localparam int unsigned NibW = 4;

  // request codes, code 3 is unused
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // free list commands from the request sequencer
  typedef struct packed {
    logic pop;
    logic push;
  } free_cmd_t;

  // free list status towards the request sequencer
  typedef struct packed {
    logic full;
    logic list_ok;
  } free_sts_t;

endpackage

### hdl/chained_hash_table_core.sv
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Key-value store with separate chaining. Bucket heads and the node pool
// live in two synchronous memories; a sequencer walks a chain one node read
// per cycle and writes back links, values and released nodes.
//
//   channel   signals                           transfer when
//   request   start_i action_i key_i value_i    start_i && !busy_o
//   result    valid_o status_o value_res_o      valid_o (one cycle)
//
// A request first takes the bucket index (a mask for a power-of-two BUCKETS,
// else a reduction four key bits a cycle), then reads the bucket head and
// the chain nodes, one node memory read a cycle, before any write-back.
// After reset the bucket memory is cleared with busy_o high. The result
// strobe lasts one cycle and cannot be held off; busy_o drops in that same
// cycle.
// ----------------------------------------------------------------------------
module chained_hash_table_core import chtab_pkg::*; #(
  parameter int unsigned BUCKETS = BucketsDef,
  parameter int unsigned NODES   = NodesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             action_i,
  input  logic [KeyW-1:0]        key_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   valid_o,
  output logic [2:0]             status_o,
  output logic signed [ValW-1:0] value_res_o
);

  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned HW  = NW + 1;
  localparam int unsigned NWD = KeyW + ValW + HW;

  // node word: key | value | next valid | next index
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_WALK, S_HIT, S_MISS,
    S_POP, S_NEW, S_LINK, S_FREE
  } state_e;

  state_e          state_q, state_d;
  logic [BW-1:0]   clr_q, clr_d;
  logic            res_valid_q, res_valid_d;
  status_e         status_q, status_d;
  logic [ValW-1:0] value_res_q, value_res_d;

  action_e         act_q, act_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic [BW-1:0]   bucket_q, bucket_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [NW-1:0]   last_q, last_d;
  logic [NWD-1:0]  last_word_q, last_word_d;
  logic            has_last_q, has_last_d;
  logic [NW-1:0]   new_q, new_d;

  // memory ports
  logic [HW-1:0]   head_mem [BUCKETS];
  logic            head_we, head_re;
  logic [BW-1:0]   head_wa, head_ra;
  logic [HW-1:0]   head_wd, head_rd_q;

  logic [NWD-1:0]  node_mem [NODES];
  logic            node_we, node_re;
  logic [NW-1:0]   node_wa, node_ra;
  logic [NWD-1:0]  node_wd, node_rd_q;

  logic            mod_start, mod_done;
  logic [BW-1:0]   mod_bucket;

  free_cmd_t       free_cmd;
  free_sts_t       free_sts;
  logic [NW-1:0]   free_head, alloc_idx;

  logic            accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  chtab_bucket #(
    .BUCKETS(BUCKETS)
  ) u_bucket (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .done_o  (mod_done),
    .bucket_o(mod_bucket)
  );

  chtab_free #(
    .NODES(NODES)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (free_cmd),
    .push_idx_i (cur_q),
    .pop_ok_i   (node_rd_q[NW]),
    .pop_link_i (node_rd_q[NW-1:0]),
    .sts_o      (free_sts),
    .list_head_o(free_head),
    .alloc_idx_o(alloc_idx)
  );

  // request sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    value_res_d = '0;
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    bucket_d    = bucket_q;
    cur_d       = cur_q;
    last_d      = last_q;
    last_word_d = last_word_q;
    has_last_d  = has_last_q;
    new_d       = new_q;
    head_we     = 1'b0;
    head_wa     = bucket_q;
    head_wd     = '0;
    head_re     = 1'b0;
    head_ra     = mod_bucket;
    node_we     = 1'b0;
    node_wa     = cur_q;
    node_wd     = node_rd_q;
    node_re     = 1'b0;
    node_ra     = cur_q;
    mod_start   = 1'b0;
    free_cmd    = '0;

    case (state_q)
      // empty every bucket after reset
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          act_d      = action_e'(action_i);
          key_d      = key_i;
          val_d      = value_i;
          has_last_d = 1'b0;
          mod_start  = 1'b1;
          state_d    = S_HASH;
        end
      end

      // wait for the bucket index, then fetch the chain head
      S_HASH: begin
        if (mod_done) begin
          bucket_d = mod_bucket;
          head_re  = 1'b1;
          head_ra  = mod_bucket;
          state_d  = S_HEAD;
        end
      end

      S_HEAD: begin
        if (head_rd_q[NW]) begin
          node_re = 1'b1;
          node_ra = head_rd_q[NW-1:0];
          cur_d   = head_rd_q[NW-1:0];
          state_d = S_WALK;
        end else begin
          state_d = S_MISS;
        end
      end

      // compare the node in hand, follow its link on a mismatch
      S_WALK: begin
        if (node_rd_q[NWD-1 -: KeyW] == key_q) begin
          state_d = S_HIT;
        end else begin
          last_d      = cur_q;
          last_word_d = node_rd_q;
          has_last_d  = 1'b1;
          if (node_rd_q[NW]) begin
            node_re = 1'b1;
            node_ra = node_rd_q[NW-1:0];
            cur_d   = node_rd_q[NW-1:0];
          end else begin
            state_d = S_MISS;
          end
        end
      end

      S_HIT: begin
        case (act_q)
          ACT_INSERT: begin
            node_we     = 1'b1;
            node_wa     = cur_q;
            node_wd     = {key_q, val_q, node_rd_q[NW:0]};
            res_valid_d = 1'b1;
            status_d    = ST_UPDATED;
            state_d     = S_IDLE;
          end
          ACT_SEARCH: begin
            res_valid_d = 1'b1;
            status_d    = ST_FOUND;
            value_res_d = node_rd_q[NW+ValW -: ValW];
            state_d     = S_IDLE;
          end
          ACT_REMOVE: begin
            // unlink: predecessor or bucket head takes the successor
            if (has_last_q) begin
              node_we = 1'b1;
              node_wa = last_q;
              node_wd = {last_word_q[NWD-1:HW], node_rd_q[NW:0]};
            end else begin
              head_we = 1'b1;
              head_wa = bucket_q;
              head_wd = node_rd_q[NW:0];
            end
            state_d = S_FREE;
          end
          default: begin
            res_valid_d = 1'b1;
            status_d    = ST_NOTFOUND;
            state_d     = S_IDLE;
          end
        endcase
      end

      S_MISS: begin
        if (act_q == ACT_INSERT) begin
          if (free_sts.full) begin
            res_valid_d = 1'b1;
            status_d    = ST_FULL;
            state_d     = S_IDLE;
          end else if (free_sts.list_ok) begin
            // released node: its link gives the next list head
            node_re = 1'b1;
            node_ra = free_head;
            state_d = S_POP;
          end else begin
            new_d        = alloc_idx;
            free_cmd.pop = 1'b1;
            state_d      = S_NEW;
          end
        end else begin
          res_valid_d = 1'b1;
          status_d    = ST_NOTFOUND;
          state_d     = S_IDLE;
        end
      end

      S_POP: begin
        new_d        = alloc_idx;
        free_cmd.pop = 1'b1;
        state_d      = S_NEW;
      end

      // fill the new node, hang it on an empty bucket directly
      S_NEW: begin
        node_we = 1'b1;
        node_wa = new_q;
        node_wd = {key_q, val_q, 1'b0, NW'(0)};
        if (has_last_q) begin
          state_d = S_LINK;
        end else begin
          head_we     = 1'b1;
          head_wa     = bucket_q;
          head_wd     = {1'b1, new_q};
          res_valid_d = 1'b1;
          status_d    = ST_INSERTED;
          state_d     = S_IDLE;
        end
      end

      // append behind the chain tail
      S_LINK: begin
        node_we     = 1'b1;
        node_wa     = last_q;
        node_wd     = {last_word_q[NWD-1:HW], 1'b1, new_q};
        res_valid_d = 1'b1;
        status_d    = ST_INSERTED;
        state_d     = S_IDLE;
      end

      // release the removed node onto the free list
      S_FREE: begin
        node_we       = 1'b1;
        node_wa       = cur_q;
        node_wd       = {node_rd_q[NWD-1:HW], free_sts.list_ok, free_head};
        free_cmd.push = 1'b1;
        res_valid_d   = 1'b1;
        status_d      = ST_REMOVED;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      status_q    <= ST_NOTFOUND;
      value_res_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
      value_res_q <= value_res_d;
    end
  end

  // request context
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    key_q       <= key_d;
    val_q       <= val_d;
    bucket_q    <= bucket_d;
    cur_q       <= cur_d;
    last_q      <= last_d;
    last_word_q <= last_word_d;
    has_last_q  <= has_last_d;
    new_q       <= new_d;
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_rd_q <= head_mem[head_ra];
    end
  end

  // node pool memory
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  assign valid_o     = res_valid_q;
  assign status_o    = status_q;
  assign value_res_o = value_res_q;

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !valid_o)
    else $error("result right after a request transfer");

  a_node_rw_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(node_we && node_re && (node_wa == node_ra)))
    else $error("node read and write to the same entry in one cycle");

  a_walk_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> $past(node_re))
    else $error("chain compare without a node read");

endmodule

### hdl/chtab_bucket.sv
// ----------------------------------------------------------------------------
// chtab_bucket
// Reduces a key to its bucket index, key modulo BUCKETS. A power-of-two
// bucket count is a mask; any other count is reduced four key bits a cycle.
// ----------------------------------------------------------------------------
module chtab_bucket import chtab_pkg::*; #(
  parameter int unsigned  BUCKETS = BucketsDef,
  localparam int unsigned BW      = $clog2(BUCKETS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [KeyW-1:0] key_i,
  output logic            done_o,
  output logic [BW-1:0]   bucket_o
);

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
    logic          done_q;
    logic [BW-1:0] bkt_q;

    // power of two: low key bits, registered on start
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bkt_q <= key_i[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bkt_q;
  end else begin : g_div
    localparam int unsigned Steps = KeyW / NibW;
    localparam int unsigned CW    = $clog2(Steps);
    localparam int unsigned TW    = BW + NibW;

    logic            run_q;
    logic            done_q;
    logic [CW-1:0]   cnt_q;
    logic [KeyW-1:0] sh_q;
    logic [BW-1:0]   rem_q;
    logic [TW-1:0]   rem_nxt;

    // one nibble step: shift in four key bits, restoring reduce
    always_comb begin
      logic [TW-1:0] t;
      t = {rem_q, sh_q[KeyW-1 -: NibW]};
      for (int j = NibW - 1; j >= 0; j--) begin
        if (t >= (TW'(BUCKETS) << j)) begin
          t = t - (TW'(BUCKETS) << j);
        end
      end
      rem_nxt = t;
    end

    // step control
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        run_q  <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          run_q <= 1'b1;
          cnt_q <= '0;
        end else if (run_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(Steps - 1)) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    // remainder and key shifter
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= key_i;
        rem_q <= '0;
      end else if (run_q) begin
        sh_q  <= sh_q << NibW;
        rem_q <= rem_nxt[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = rem_q;
  end

endmodule

### hdl/chtab_free.sv
// ----------------------------------------------------------------------------
// chtab_free
// Node allocator: a LIFO list of released nodes linked through the node
// memory, backed by a counter of nodes never handed out.
// ----------------------------------------------------------------------------
module chtab_free import chtab_pkg::*; #(
  parameter int unsigned  NODES = NodesDef,
  localparam int unsigned NW    = $clog2(NODES),
  localparam int unsigned CW    = $clog2(NODES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  free_cmd_t     cmd_i,
  input  logic [NW-1:0] push_idx_i,
  input  logic          pop_ok_i,
  input  logic [NW-1:0] pop_link_i,
  output free_sts_t     sts_o,
  output logic [NW-1:0] list_head_o,
  output logic [NW-1:0] alloc_idx_o
);

  logic          list_ok_q;
  logic [NW-1:0] list_head_q;
  logic [CW-1:0] fresh_q;

  // released nodes go first, then untouched nodes in index order
  assign sts_o.list_ok = list_ok_q;
  assign sts_o.full    = !list_ok_q && (fresh_q == CW'(NODES));
  assign list_head_o   = list_head_q;
  assign alloc_idx_o   = list_ok_q ? list_head_q : fresh_q[NW-1:0];

  // list head and fresh counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_ok_q   <= 1'b0;
      list_head_q <= '0;
      fresh_q     <= '0;
    end else if (cmd_i.pop) begin
      if (list_ok_q) begin
        list_ok_q   <= pop_ok_i;
        list_head_q <= pop_link_i;
      end else begin
        fresh_q <= fresh_q + 1'b1;
      end
    end else if (cmd_i.push) begin
      list_ok_q   <= 1'b1;
      list_head_q <= push_idx_i;
    end
  end

  a_no_pop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !sts_o.full)
    else $error("allocation from an empty pool");

  a_pop_push_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.pop && cmd_i.push))
    else $error("allocate and release in the same cycle");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CW'(NODES))
    else $error("fresh node counter past pool size");

endmodule

### tb/tb_chained_hash_table_core.sv
// ----------------------------------------------------------------------------
// tb_chained_hash_table_core
// Self-checking bench for the chained hash table core. A directed table of
// requests covers the empty table, value and key extremes, head, middle and
// tail removal, updates and the unused action code. It is followed by a
// pool-overflow fill and three random phases with different sender idle
// profiles. Every result is compared in order against a behavioral copy of
// the table: bucket heads, node links and a free stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chained_hash_table_core;
  import chtab_pkg::*;

  localparam int unsigned HashBuckets = BucketsDef;
  localparam int unsigned PoolNodes   = NodesDef;
  localparam int unsigned KeyPoolSize = 96;
  localparam int unsigned PhaseItems  = 490;
  localparam int unsigned FillItems   = 72;
  localparam int unsigned DrainCycles = 80;
  localparam logic [1:0]  ActUnused   = 2'd3;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] val;
  } hash_res_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [31:0]        key;
    logic signed [31:0] val;
    logic               typed;
    hash_res_t          want;
  } req_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [1:0]             action_i;
  logic [KeyW-1:0]        key_i;
  logic signed [ValW-1:0] value_i;
  logic                   valid_o;
  logic [2:0]             status_o;
  logic signed [ValW-1:0] value_res_o;

  // behavioral copy of the table
  bit                 head_live [HashBuckets];
  int unsigned        head_idx  [HashBuckets];
  logic [31:0]        slot_key  [PoolNodes];
  logic signed [31:0] slot_val  [PoolNodes];
  bit                 link_live [PoolNodes];
  int unsigned        link_idx  [PoolNodes];
  int unsigned        spare_stack [PoolNodes];
  int unsigned        spare_top;

  hash_res_t   awaited_results [$];
  req_row_t    dir_rows [$];
  logic [31:0] key_pool [KeyPoolSize];

  int unsigned req_cnt;
  int unsigned res_cnt;
  int unsigned mismatch_cnt;
  int unsigned status_seen [6];

  chained_hash_table_core #(
    .BUCKETS(HashBuckets),
    .NODES  (PoolNodes)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .action_i   (action_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .value_res_o(value_res_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one request to the table copy and return the result it gives
  function automatic hash_res_t table_access(input logic [1:0] act, input logic [31:0] key,
                                             input logic signed [31:0] val);
    hash_res_t   res;
    int unsigned b;
    int unsigned cur;
    int unsigned prev;
    int unsigned steps;
    int unsigned slot;
    bit          walk;
    bit          hit;
    bit          has_prev;
    res      = '{status: ST_NOTFOUND, val: '0};
    b        = key % HashBuckets;
    walk     = head_live[b];
    cur      = head_idx[b];
    prev     = 0;
    has_prev = 1'b0;
    hit      = 1'b0;
    steps    = 0;
    // chain walk, prev ends on the tail when nothing matches
    while (walk && !hit && steps < PoolNodes) begin
      if (slot_key[cur] == key) begin
        hit = 1'b1;
      end else begin
        prev     = cur;
        has_prev = 1'b1;
        walk     = link_live[cur];
        cur      = link_idx[cur];
        steps++;
      end
    end
    case (act)
      ACT_INSERT: begin
        if (hit) begin
          slot_val[cur] = val;
          res.status    = ST_UPDATED;
        end else if (spare_top == 0) begin
          res.status = ST_FULL;
        end else begin
          spare_top--;
          slot            = spare_stack[spare_top];
          slot_key[slot]  = key;
          slot_val[slot]  = val;
          link_live[slot] = 1'b0;
          link_idx[slot]  = 0;
          // append at the tail, or start the chain
          if (has_prev) begin
            link_live[prev] = 1'b1;
            link_idx[prev]  = slot;
          end else begin
            head_live[b] = 1'b1;
            head_idx[b]  = slot;
          end
          res.status = ST_INSERTED;
        end
      end
      ACT_SEARCH: begin
        if (hit) begin
          res.status = ST_FOUND;
          res.val    = slot_val[cur];
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          // unlink, head node included, then release to the free stack
          if (has_prev) begin
            link_live[prev] = link_live[cur];
            link_idx[prev]  = link_idx[cur];
          end else begin
            head_live[b] = link_live[cur];
            head_idx[b]  = link_idx[cur];
          end
          link_live[cur] = 1'b0;
          if (spare_top < PoolNodes) begin
            spare_stack[spare_top] = cur;
            spare_top++;
          end
          res.status = ST_REMOVED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // drive one request and hold it until the transfer
  task automatic send_req(input logic [1:0] act, input logic [31:0] key,
                          input logic signed [31:0] val, input logic typed,
                          input hash_res_t typed_res);
    hash_res_t want;
    start_i  <= 1'b1;
    action_i <= act;
    key_i    <= key;
    value_i  <= val;
    do @(posedge clk_i); while (busy_o);
    want = table_access(act, key, val);
    if (typed) want = typed_res;
    awaited_results.push_back(want);
    req_cnt++;
  endtask

  // random sender gap with noise on the payload
  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i  <= 1'b0;
      action_i <= 2'($urandom_range(3));
      key_i    <= $urandom();
      value_i  <= $urandom();
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker, strobe sampled at the edge that ends its cycle
  always @(posedge clk_i) begin : p_result_check
    hash_res_t want;
    if (rst_ni && valid_o) begin
      res_cnt++;
      if (status_o < 3'd6) status_seen[status_o]++;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: status %0d value %0d",
                                status_o, value_res_o));
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || value_res_o !== want.val) begin
          flag_mismatch($sformatf("status exp %0d got %0d, value exp %0d got %0d",
                                  want.status, status_o, want.val, value_res_o));
        end
      end
    end
  end

  initial begin : p_watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : p_stimulus
    int unsigned idle_pct;
    int unsigned ins_w;
    int unsigned srch_w;
    int unsigned rem_w;
    int unsigned pick;
    logic [1:0]  act;
    logic [31:0] key;

    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    action_i     <= ACT_INSERT;
    key_i        <= '0;
    value_i      <= '0;
    req_cnt      = 0;
    res_cnt      = 0;
    mismatch_cnt = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // table copy after reset: all buckets empty, node 0 taken first
    foreach (head_live[i]) begin
      head_live[i] = 1'b0;
      head_idx[i]  = 0;
    end
    foreach (spare_stack[i]) begin
      spare_stack[i] = PoolNodes - 1 - i;
      link_live[i]   = 1'b0;
      link_idx[i]    = 0;
      slot_key[i]    = '0;
      slot_val[i]    = '0;
    end
    spare_top = PoolNodes;

    // distinct keys, bits 11:4 carry the index, a third share bucket 5
    foreach (key_pool[i]) begin
      key = $urandom();
      key[11:4] = 8'(i);
      if (i >= 2 && i < 34) key[3:0] = 4'd5;
      key_pool[i] = key;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    // directed table
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0000, 32'sh0, 1'b1, '{ST_NOTFOUND, 32'sh0}});
    dir_rows.push_back('{ACT_REMOVE, 32'hFFFF_FFFF, 32'sh0, 1'b1, '{ST_NOTFOUND, 32'sh0}});
    dir_rows.push_back('{ActUnused, 32'h0000_0000, 32'sh1, 1'b1, '{ST_NOTFOUND, 32'sh0}});
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b1,
                         '{ST_INSERTED, 32'sh0}});
    dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b1,
                         '{ST_INSERTED, 32'sh0}});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0000, 32'sh0, 1'b1,
                         '{ST_FOUND, 32'sh7FFF_FFFF}});
    dir_rows.push_back('{ACT_SEARCH, 32'hFFFF_FFFF, 32'sh0, 1'b1,
                         '{ST_FOUND, 32'sh8000_0000}});
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0000, 32'shFFFF_FFFF, 1'b1,
                         '{ST_UPDATED, 32'sh0}});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0000, 32'sh0, 1'b1,
                         '{ST_FOUND, 32'shFFFF_FFFF}});
    // chain of four in bucket 0, then middle, head and tail removal
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0010, 32'sh1, 1'b0, '0});
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0020, 32'sh2, 1'b0, '0});
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0030, 32'sh3, 1'b0, '0});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0020, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_REMOVE, 32'h0000_0010, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0030, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0000, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_REMOVE, 32'h0000_0030, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_SEARCH, 32'h0000_0020, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ActUnused, 32'h0000_0020, 32'sh55, 1'b0, '0});
    dir_rows.push_back('{ACT_INSERT, 32'h0000_0020, 32'sh0, 1'b0, '0});
    dir_rows.push_back('{ACT_SEARCH, 32'hFFFF_FFF0, 32'sh0, 1'b1, '{ST_NOTFOUND, 32'sh0}});
    dir_rows.push_back('{ACT_REMOVE, 32'h0000_0020, 32'sh0, 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].act, dir_rows[i].key, dir_rows[i].val, dir_rows[i].typed,
               dir_rows[i].want);
    end
    drain_results();

    // fill past pool capacity so that inserts hit a full table
    for (int unsigned n = 0; n < FillItems; n++) begin
      sender_gap(16);
      send_req(ACT_INSERT, key_pool[n], $urandom(), 1'b0, '0);
    end
    drain_results();

    // random phases: sender idles 16%, then 46%, then never
    for (int unsigned ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 16 : (ph == 1) ? 46 : 0;
      ins_w    = (ph == 1) ? 30 : (ph == 2) ? 45 : 40;
      srch_w   = (ph == 1) ? 30 : 25;
      rem_w    = (ph == 1) ? 35 : (ph == 2) ? 25 : 30;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        sender_gap(idle_pct);
        pick = $urandom_range(99);
        if (pick < ins_w) act = ACT_INSERT;
        else if (pick < ins_w + srch_w) act = ACT_SEARCH;
        else if (pick < ins_w + srch_w + rem_w) act = ACT_REMOVE;
        else act = ActUnused;
        key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(KeyPoolSize - 1)]
                                         : $urandom();
        send_req(act, key, $urandom(), 1'b0, '0);
        if (n == PhaseItems / 2) drain_results();
      end
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end

    $display("covered %0d requests over three sender idle profiles, %0d results checked",
             req_cnt, res_cnt);
    $display("status mix: ins %0d upd %0d found %0d miss %0d removed %0d full %0d, %0d bad",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
